// ===== hdl/obb_overlap_separating_axis_assert.svh =====
// Assertion macros for the oriented-box overlap block.
// Included by the modules that check their own pipeline; needs no package.
`ifndef OBB_OVERLAP_SEPARATING_AXIS_ASSERT_SVH
`define OBB_OVERLAP_SEPARATING_AXIS_ASSERT_SVH
`ifndef SYNTHESIS
`define OBB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("obb assertion failed: same-cycle implication");
`define OBB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("obb assertion failed: next-cycle implication");
`else
`define OBB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define OBB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/obbsat_pkg.sv =====
// Shared constants for the oriented-box separating-axis block.
// No dependencies; used by the channel interfaces and the top level.
package obbsat_pkg;
  localparam int VEC_W     = 63;
  localparam int CFG_IDX_W = 3;
  localparam int DEPTH_W   = 32;
  localparam int FRAC      = 10;
  localparam int HALF      = 512;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_2  = 3'd4;
endpackage

// ===== hdl/obbsat_if.sv =====
// Valid/ready channels of the oriented-box separating-axis block:
// query requests, result requests and configuration writes. Uses obbsat_pkg.
interface obbsat_in_if;
  import obbsat_pkg::*;
  logic             valid;
  logic             ready;
  logic [VEC_W-1:0] other_center;
  logic [VEC_W-1:0] other_extents;
  logic [VEC_W-1:0] other_axis_0;
  logic [VEC_W-1:0] other_axis_1;
  logic [VEC_W-1:0] other_axis_2;
  logic [VEC_W-1:0] overlap_normal;
  modport source (output valid, other_center, other_extents, other_axis_0, other_axis_1,
                  other_axis_2, overlap_normal, input ready);
  modport sink (input valid, other_center, other_extents, other_axis_0, other_axis_1,
                other_axis_2, overlap_normal, output ready);
endinterface

interface obbsat_out_if;
  import obbsat_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      separated;
  logic signed [DEPTH_W-1:0] overlap_depth;
  modport source (output valid, separated, overlap_depth, input ready);
  modport sink (input valid, separated, overlap_depth, output ready);
endinterface

interface obbsat_cfg_if;
  import obbsat_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [VEC_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/obb_overlap_separating_axis.sv =====
// Oriented-box overlap test by separating axes, eight-stage pipeline.
// Depends on obbsat_pkg, obbsat_if.sv and obb_overlap_separating_axis_assert.svh.
//
// Usage:
//   cfg_ch  writes the reference box: index 0 center, 1 half extents, 2..4 axes.
//           It is always ready; write only while no query is in flight.
//   in_ch   one query request per accepted cycle: the other box and a normal.
//   out_ch  one result request per query: separated flag and overlap depth
//           (zero when separated), in query order.
// An accepted query passes through every stage to out_ch.valid. Throughput is one query
// per cycle while out_ch is ready; the sixteen projection units (fifteen test axes and
// the normal) each own their multipliers, so unstalled stages take a new item each cycle.
// Stages: center difference and cross partial products; rounded cross axes;
// component products; dot sums and rounding; extent products; radius sums;
// separation compare; depth rounding into the output register.
// Reset clears the reference box registers to zero and empties the pipeline.
// When the receiver stalls, each full stage holds while the stage after it holds,
// so bubbles close up and in_ch.ready falls only once all eight stages hold data.
`include "obb_overlap_separating_axis_assert.svh"

module obb_overlap_separating_axis #(
  parameter int COORD_BITS = 21
) (
  input logic           clk,
  input logic           rst_n,
  obbsat_cfg_if.sink    cfg_ch,
  obbsat_in_if.sink     in_ch,
  obbsat_out_if.source  out_ch
);
  import obbsat_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int NS   = 8;
  localparam int NAX  = 16;
  localparam int NRM  = 15;
  localparam int NB   = 6;
  localparam int DW   = C + 1;
  localparam int MW   = 2 * C;
  localparam int XW   = 2 * C + 2;
  localparam int PDW  = 2 * C + 1;
  localparam int DOTW = 2 * C + 2;
  localparam int PRW  = 2 * C + 3;
  localparam int KW   = DOTW - FRAC;
  localparam int TW   = KW + C;
  localparam int SW   = 3 * C + 14;
  localparam int QW   = SW - FRAC;

  localparam logic signed [XW-FRAC-1:0] CHI = (XW - FRAC)'(2 ** (C - 1) - 1);
  localparam logic signed [XW-FRAC-1:0] CLO = ~CHI;
  localparam logic signed [QW-1:0]      DHI = QW'(2147483647);
  localparam logic signed [QW-1:0]      DLO = ~DHI;

  typedef logic signed [C-1:0] crd_t;

  function automatic crd_t comp(input logic [VEC_W-1:0] w, input int k);
    comp = w[k*C +: C];
  endfunction

  function automatic crd_t rnd_sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0]      t;
    logic signed [XW-FRAC-1:0] q;
    t = v + XW'(HALF);
    q = t[XW-1:FRAC];
    if (q > CHI) rnd_sat = CHI[C-1:0];
    else if (q < CLO) rnd_sat = CLO[C-1:0];
    else rnd_sat = q[C-1:0];
  endfunction

  // Reference box registers.
  logic [VEC_W-1:0] cen_r, ext_r;
  logic [VEC_W-1:0] rax_r [3];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r  <= '0;
      ext_r  <= '0;
      rax_r[0] <= '0;
      rax_r[1] <= '0;
      rax_r[2] <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_CENTER:  cen_r    <= cfg_ch.data;
        REG_EXTENTS: ext_r    <= cfg_ch.data;
        REG_AXIS_0:  rax_r[0] <= cfg_ch.data;
        REG_AXIS_1:  rax_r[1] <= cfg_ch.data;
        REG_AXIS_2:  rax_r[2] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  crd_t rc [3];
  crd_t re [3];
  crd_t ra [3][3];
  crd_t oc [3];
  crd_t oe_in [3];
  crd_t oa_in [3][3];
  crd_t nrm_in [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rc[k]     = comp(cen_r, k);
      re[k]     = comp(ext_r, k);
      oc[k]     = comp(in_ch.other_center, k);
      oe_in[k]  = comp(in_ch.other_extents, k);
      nrm_in[k] = comp(in_ch.overlap_normal, k);
      oa_in[0][k] = comp(in_ch.other_axis_0, k);
      oa_in[1][k] = comp(in_ch.other_axis_1, k);
      oa_in[2][k] = comp(in_ch.other_axis_2, k);
      for (int a = 0; a < 3; a++) ra[a][k] = comp(rax_r[a], k);
    end
  end

  // Handshake: a stage loads when it is empty or the next stage loads.
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ch.ready;
    for (int s = NS - 2; s >= 0; s--) en[s] = !v_r[s] || en[s+1];
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_ch.valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  // Stage 1: center difference and cross-product partial products.
  crd_t                  oa1_r [3][3];
  crd_t                  oe1_r [3];
  crd_t                  nrm1_r [3];
  logic signed [DW-1:0]  d1_r [3];
  logic signed [MW-1:0]  xp1_r [3][3][3][2];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        d1_r[k]   <= DW'(oc[k]) - DW'(rc[k]);
        oe1_r[k]  <= oe_in[k];
        nrm1_r[k] <= nrm_in[k];
        for (int b = 0; b < 3; b++) oa1_r[b][k] <= oa_in[b][k];
      end
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          for (int k = 0; k < 3; k++) begin
            xp1_r[a][b][k][0] <= ra[a][(k == 2) ? 0 : k + 1] * oa_in[b][(k == 0) ? 2 : k - 1];
            xp1_r[a][b][k][1] <= ra[a][(k == 0) ? 2 : k - 1] * oa_in[b][(k == 2) ? 0 : k + 1];
          end
        end
      end
    end
  end

  // Stage 2: candidate axes, with cross axes rounded and saturated.
  crd_t                 cx [3][3][3];
  logic [NAX-1:0]       dg_nxt;
  crd_t                 ax2_r [NAX][3];
  logic [NAX-1:0]       dg2_r;
  crd_t                 oa2_r [3][3];
  crd_t                 oe2_r [3];
  logic signed [DW-1:0] d2_r [3];

  always_comb begin
    dg_nxt = '0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        for (int k = 0; k < 3; k++) begin
          cx[a][b][k] = rnd_sat(XW'(xp1_r[a][b][k][0]) - XW'(xp1_r[a][b][k][1]));
        end
        // Parallel edges give a null axis, which never separates.
        dg_nxt[6 + a*3 + b] = (cx[a][b][0] == '0) && (cx[a][b][1] == '0)
                              && (cx[a][b][2] == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dg2_r <= dg_nxt;
      for (int k = 0; k < 3; k++) begin
        d2_r[k]  <= d1_r[k];
        oe2_r[k] <= oe1_r[k];
        ax2_r[NRM][k] <= nrm1_r[k];
        for (int a = 0; a < 3; a++) begin
          oa2_r[a][k]   <= oa1_r[a][k];
          ax2_r[a][k]   <= ra[a][k];
          ax2_r[3+a][k] <= oa1_r[a][k];
          for (int b = 0; b < 3; b++) ax2_r[6 + a*3 + b][k] <= cx[a][b][k];
        end
      end
    end
  end

  // Stage 3: component products against both boxes' axes and the center offset.
  crd_t                  bx [NB][3];
  logic signed [MW-1:0]  m3_r [NAX][NB][3];
  logic signed [PDW-1:0] pd3_r [NAX][3];
  logic [NAX-1:0]        dg3_r;
  crd_t                  oe3_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int a = 0; a < 3; a++) begin
        bx[a][k]   = ra[a][k];
        bx[3+a][k] = oa2_r[a][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dg3_r <= dg2_r;
      for (int k = 0; k < 3; k++) oe3_r[k] <= oe2_r[k];
      for (int j = 0; j < NAX; j++) begin
        for (int k = 0; k < 3; k++) begin
          pd3_r[j][k] <= ax2_r[j][k] * d2_r[k];
          for (int i = 0; i < NB; i++) m3_r[j][i][k] <= ax2_r[j][k] * bx[i][k];
        end
      end
    end
  end

  // Stage 4: dot sums, absolute value and rounding of the radius coefficients.
  logic signed [DOTW-1:0] dot [NAX][NB];
  logic signed [DOTW-1:0] adot [NAX][NB];
  logic signed [KW-1:0]   cf_nxt [NAX][NB];
  logic signed [KW-1:0]   cf4_r [NAX][NB];
  logic signed [PRW-1:0]  p4_r [NAX];
  logic [NAX-1:0]         dg4_r;
  crd_t                   oe4_r [3];

  always_comb begin
    for (int j = 0; j < NAX; j++) begin
      for (int i = 0; i < NB; i++) begin
        dot[j][i]  = DOTW'(m3_r[j][i][0]) + DOTW'(m3_r[j][i][1]) + DOTW'(m3_r[j][i][2]);
        adot[j][i] = (dot[j][i] < 0) ? -dot[j][i] : dot[j][i];
        adot[j][i] = adot[j][i] + DOTW'(HALF);
        cf_nxt[j][i] = adot[j][i][DOTW-1:FRAC];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      dg4_r <= dg3_r;
      for (int k = 0; k < 3; k++) oe4_r[k] <= oe3_r[k];
      for (int j = 0; j < NAX; j++) begin
        p4_r[j] <= PRW'(pd3_r[j][0]) + PRW'(pd3_r[j][1]) + PRW'(pd3_r[j][2]);
        for (int i = 0; i < NB; i++) cf4_r[j][i] <= cf_nxt[j][i];
      end
    end
  end

  // Stage 5: radius terms, coefficient times extent.
  crd_t                  ex [NB];
  logic signed [TW-1:0]  t5_r [NAX][NB];
  logic signed [PRW-1:0] p5_r [NAX];
  logic [NAX-1:0]        dg5_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ex[a]   = re[a];
      ex[3+a] = oe4_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      dg5_r <= dg4_r;
      for (int j = 0; j < NAX; j++) begin
        p5_r[j] <= p4_r[j];
        for (int i = 0; i < NB; i++) t5_r[j][i] <= cf4_r[j][i] * ex[i];
      end
    end
  end

  // Stage 6: radius sums.
  logic signed [SW-1:0] r6_r [NAX];
  logic signed [SW-1:0] p6_r [NAX];
  logic [NAX-1:0]       dg6_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      dg6_r <= dg5_r;
      for (int j = 0; j < NAX; j++) begin
        p6_r[j] <= SW'(p5_r[j]);
        r6_r[j] <= SW'(t5_r[j][0]) + SW'(t5_r[j][1]) + SW'(t5_r[j][2])
                 + SW'(t5_r[j][3]) + SW'(t5_r[j][4]) + SW'(t5_r[j][5]);
      end
    end
  end

  // Stage 7: separation compare per axis, raw depth along the normal.
  logic [NRM-1:0]       sep_nxt;
  logic signed [SW-1:0] apn;
  logic [NRM-1:0]       sep7_r;
  logic signed [SW-1:0] raw7_r;

  always_comb begin
    for (int j = 0; j < NRM; j++) begin
      sep_nxt[j] = !dg6_r[j] && ((p6_r[j] >= r6_r[j]) || (p6_r[j] <= -r6_r[j]));
    end
    apn = (p6_r[NRM] < 0) ? -p6_r[NRM] : p6_r[NRM];
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      sep7_r <= sep_nxt;
      raw7_r <= r6_r[NRM] - apn;
    end
  end

  // Stage 8: output register, depth rounded and saturated.
  logic signed [SW-1:0]      rt;
  logic signed [QW-1:0]      dq;
  logic signed [DEPTH_W-1:0] dep_nxt;
  logic                      sep_r;
  logic signed [DEPTH_W-1:0] dep_r;

  always_comb begin
    rt = raw7_r + SW'(HALF);
    dq = rt[SW-1:FRAC];
    if (|sep7_r) dep_nxt = '0;
    else if (dq > DHI) dep_nxt = DHI[DEPTH_W-1:0];
    else if (dq < DLO) dep_nxt = DLO[DEPTH_W-1:0];
    else dep_nxt = dq[DEPTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      sep_r <= |sep7_r;
      dep_r <= dep_nxt;
    end
  end

  assign out_ch.valid         = v_r[NS-1];
  assign out_ch.separated     = sep_r;
  assign out_ch.overlap_depth = dep_r;

  `OBB_ASSERT_IMP(a_sep_zero_depth, clk, rst_n, out_ch.valid && out_ch.separated, out_ch.overlap_depth == '0)
  `OBB_ASSERT_IMP(a_busy_means_full, clk, rst_n, !in_ch.ready, &v_r)
  `OBB_ASSERT_NXT(a_mid_stage_holds, clk, rst_n, v_r[3] && !en[3], v_r[3])
endmodule
